FILE: rtl/core/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared command and status codes and the cell control word of the stable
// sorted priority queue.
// ----------------------------------------------------------------------------
package ssq_pkg;

  // command codes, the unused code is decoded as a dequeue
  typedef enum logic [1:0] {
    CMD_SORTED  = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_DEQUEUE = 2'd2
  } ssq_cmd_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } ssq_status_e;

  // control broadcast to every cell
  typedef struct packed {
    logic ins;     // insert into the row, everything from the slot on shifts right
    logic sorted;  // slot chosen by team compare rather than at the tail
    logic deq;     // remove the head, everything shifts left
  } ssq_ctl_t;

endpackage

FILE: rtl/core/ssq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cmd_if / ssq_res_if
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface ssq_cmd_if #(
  parameter int unsigned MEMBER_BITS = 16,
  parameter int unsigned TEAM_BITS   = 8
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [MEMBER_BITS-1:0] member;
  logic [TEAM_BITS-1:0]   team;

  modport source (output valid, output cmd, output member, output team, input ready);
  modport sink   (input valid, input cmd, input member, input team, output ready);
endinterface

interface ssq_res_if #(
  parameter int unsigned MEMBER_BITS = 16,
  parameter int unsigned TEAM_BITS   = 8,
  parameter int unsigned OCC_BITS    = 5
);
  logic                   valid;
  logic                   ready;
  logic [1:0]             status;
  logic [MEMBER_BITS-1:0] out_member;
  logic [TEAM_BITS-1:0]   out_team;
  logic [OCC_BITS-1:0]    occupancy;

  modport source (output valid, output status, output out_member, output out_team,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_member, input out_team,
                  input occupancy, output ready);
endinterface

FILE: rtl/core/ssq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the queue row. Holds an entry, compares its team with the new
// one, and takes the new entry, its left neighbour or its right neighbour.
// ----------------------------------------------------------------------------
module ssq_cell
  import ssq_pkg::*;
#(
  parameter int unsigned MEMBER_BITS = 16,
  parameter int unsigned TEAM_BITS   = 8
) (
  input  logic                   clk_i,
  input  ssq_ctl_t               ctl_i,
  input  logic                   occ_i,
  input  logic [MEMBER_BITS-1:0] new_member_i,
  input  logic [TEAM_BITS-1:0]   new_team_i,
  input  logic [MEMBER_BITS-1:0] left_member_i,
  input  logic [TEAM_BITS-1:0]   left_team_i,
  input  logic [MEMBER_BITS-1:0] right_member_i,
  input  logic [TEAM_BITS-1:0]   right_team_i,
  input  logic                   found_i,
  output logic                   found_o,
  output logic [MEMBER_BITS-1:0] member_o,
  output logic [TEAM_BITS-1:0]   team_o
);

  logic [MEMBER_BITS-1:0] member_q, member_d;
  logic [TEAM_BITS-1:0]   team_q, team_d;
  logic                   hit;

  // slot is the insert point if empty, or if its team is greater on a sorted insert
  assign hit     = !occ_i || (ctl_i.sorted && (team_q > new_team_i));
  assign found_o = found_i | hit;

  // next entry: hold, shift right, load new, or shift left
  always_comb begin
    member_d = member_q;
    team_d   = team_q;
    if (ctl_i.ins) begin
      if (found_i) begin
        member_d = left_member_i;
        team_d   = left_team_i;
      end else if (hit) begin
        member_d = new_member_i;
        team_d   = new_team_i;
      end
    end else if (ctl_i.deq) begin
      member_d = right_member_i;
      team_d   = right_team_i;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    member_q <= member_d;
    team_q   <= team_d;
  end

  assign member_o = member_q;
  assign team_o   = team_q;

endmodule

FILE: rtl/core/stable_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// throughput: one command item per cycle while the output register is free or being taken
// the result sits in an output register; a new item is taken while it is taken too
// reset clears the entry count and the output valid; the row of cells is not cleared
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue_unit
// Bounded queue of (member, team) entries kept in a row of cells, ordered by
// team with arrival order kept within a team, plus append and dequeue.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue_unit
  import ssq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MEMBER_BITS = 16,
  parameter int unsigned TEAM_BITS   = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssq_cmd_if.sink   cmd_i,
  ssq_res_if.source res_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0]        count_q, count_d;
  logic                   res_valid_q;
  logic [1:0]             status_q, status_d;
  logic [MEMBER_BITS-1:0] out_member_q, out_member_d;
  logic [TEAM_BITS-1:0]   out_team_q, out_team_d;
  logic                   accept;
  logic                   full, empty, is_deq;
  ssq_ctl_t               ctl;

  logic [MEMBER_BITS-1:0] cell_member [QUEUE_DEPTH];
  logic [TEAM_BITS-1:0]   cell_team   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]   found;

  // handshake: take an item whenever the output register is free or being taken
  assign cmd_i.ready = !res_valid_q || res_o.ready;
  assign accept      = cmd_i.valid && cmd_i.ready;

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // command decode
  always_comb begin
    is_deq     = 1'b0;
    ctl.sorted = 1'b0;
    case (cmd_i.cmd)
      CMD_SORTED: ctl.sorted = 1'b1;
      CMD_APPEND: ctl.sorted = 1'b0;
      default:    is_deq     = 1'b1;
    endcase
    ctl.ins = accept && !is_deq && !full;
    ctl.deq = accept && is_deq && !empty;
  end

  // row of cells with the insert-point search rippling from head to tail
  assign found[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [MEMBER_BITS-1:0] left_member, right_member;
    logic [TEAM_BITS-1:0]   left_team, right_team;

    if (i == 0) begin : g_head
      assign left_member = cmd_i.member;
      assign left_team   = cmd_i.team;
    end else begin : g_body
      assign left_member = cell_member[i-1];
      assign left_team   = cell_team[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_member = cell_member[i];
      assign right_team   = cell_team[i];
    end else begin : g_inner
      assign right_member = cell_member[i+1];
      assign right_team   = cell_team[i+1];
    end

    ssq_cell #(
      .MEMBER_BITS (MEMBER_BITS),
      .TEAM_BITS   (TEAM_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .ctl_i          (ctl),
      .occ_i          (count_q > CntW'(i)),
      .new_member_i   (cmd_i.member),
      .new_team_i     (cmd_i.team),
      .left_member_i  (left_member),
      .left_team_i    (left_team),
      .right_member_i (right_member),
      .right_team_i   (right_team),
      .found_i        (found[i]),
      .found_o        (found[i+1]),
      .member_o       (cell_member[i]),
      .team_o         (cell_team[i])
    );
  end

  // result and entry count for the accepted item
  always_comb begin
    count_d      = count_q;
    status_d     = ST_INSERTED;
    out_member_d = '0;
    out_team_d   = '0;
    if (is_deq) begin
      if (empty) begin
        status_d = ST_EMPTY;
      end else begin
        status_d     = ST_DEQUEUED;
        out_member_d = cell_member[0];
        out_team_d   = cell_team[0];
        count_d      = count_q - CntW'(1);
      end
    end else if (full) begin
      status_d = ST_FULL;
    end else begin
      count_d = count_q + CntW'(1);
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q     <= status_d;
      out_member_q <= out_member_d;
      out_team_q   <= out_team_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.status     = status_q;
  assign res_o.out_member = out_member_q;
  assign res_o.out_team   = out_team_q;
  assign res_o.occupancy  = count_q;

endmodule

FILE: rtl/core/ssq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks of the stable sorted priority queue, bound to the top.
// ----------------------------------------------------------------------------
module ssq_checker
  import ssq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned MEMBER_BITS = 16,
  parameter int unsigned TEAM_BITS   = 8,
  parameter int unsigned OCC_BITS    = 5
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   res_valid_i,
  input logic                   res_ready_i,
  input logic [1:0]             status_i,
  input logic [MEMBER_BITS-1:0] out_member_i,
  input logic [TEAM_BITS-1:0]   out_team_i,
  input logic [OCC_BITS-1:0]    occupancy_i
);

  // a stalled item holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(status_i)
      && $stable(out_member_i) && $stable(out_team_i) && $stable(occupancy_i))
    else $error("stalled result changed");

  // an empty dequeue reports nothing held and no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ST_EMPTY |->
      occupancy_i == '0 && out_member_i == '0 && out_team_i == '0)
    else $error("empty result inconsistent");

  // a dropped insert means the queue was full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ST_FULL |->
      occupancy_i == OCC_BITS'(QUEUE_DEPTH) && out_member_i == '0 && out_team_i == '0)
    else $error("full result inconsistent");

  // an insert leaves at least one entry and returns no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ST_INSERTED |->
      occupancy_i != '0 && out_member_i == '0 && out_team_i == '0)
    else $error("insert result inconsistent");

  // a dequeue never leaves the queue full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && status_i == ST_DEQUEUED |-> occupancy_i < OCC_BITS'(QUEUE_DEPTH))
    else $error("dequeue result inconsistent");

endmodule

bind stable_sorted_priority_queue_unit ssq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH),
  .MEMBER_BITS (MEMBER_BITS),
  .TEAM_BITS   (TEAM_BITS),
  .OCC_BITS    ($clog2(QUEUE_DEPTH + 1))
) u_ssq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .status_i     (res_o.status),
  .out_member_i (res_o.out_member),
  .out_team_i   (res_o.out_team),
  .occupancy_i  (res_o.occupancy)
);

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the stable sorted priority queue. A clocked driver offers
// command items from a pending queue with random gaps, a clocked monitor
// takes result items with random stalls and checks each one against a
// predictor that keeps its own copy of the entry row. The receiver holds
// off for long stretches so that the block stalls its input.
// ----------------------------------------------------------------------------
module tb_top;
  import ssq_pkg::*;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned MEM_W    = 16;
  localparam int unsigned TEAM_W   = 8;
  localparam int unsigned OCC_W    = 5;
  localparam int          N_RANDOM = 1400;
  localparam int          SETTLE   = 4;

  // the spare command code, decoded as a dequeue
  localparam logic [1:0] CMD_SPARE = 2'd3;

  // stimulus phases and team value spreads
  typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED } phase_e;
  typedef enum int { TM_NARROW, TM_EDGES, TM_ANY } team_mode_e;

  typedef struct {
    logic [1:0]        cmd;
    logic [MEM_W-1:0]  member;
    logic [TEAM_W-1:0] team;
  } cmd_item_t;

  typedef struct {
    ssq_status_e       status;
    logic [MEM_W-1:0]  member;
    logic [TEAM_W-1:0] team;
    logic [OCC_W-1:0]  occ;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  ssq_cmd_if #(.MEMBER_BITS(MEM_W), .TEAM_BITS(TEAM_W)) cmd_if ();
  ssq_res_if #(.MEMBER_BITS(MEM_W), .TEAM_BITS(TEAM_W), .OCC_BITS(OCC_W)) res_if ();

  stable_sorted_priority_queue_unit #(
    .QUEUE_DEPTH(DEPTH),
    .MEMBER_BITS(MEM_W),
    .TEAM_BITS  (TEAM_W)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd_if),
    .res_o (res_if)
  );

  // clock
  always #5 clk = ~clk;

  cmd_item_t pending_items[$];
  result_t   expected_results[$];

  // predicted entry row
  logic [MEM_W-1:0]  row_member[DEPTH];
  logic [TEAM_W-1:0] row_team[DEPTH];
  int unsigned       row_count;

  int  accepted_items = 0;
  int  total_items    = 0;
  int  errors         = 0;
  bit  cmd_taken      = 1'b0;
  bit  res_taken      = 1'b0;
  bit  hold_recv      = 1'b0;
  bit  calm_send      = 1'b0;
  bit  calm_recv      = 1'b0;
  int  send_gap       = 0;
  int  recv_gap       = 0;

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // slot for a sorted insert: head if below the head, else ahead of the
  // first later entry with a greater team, else the tail
  function automatic int unsigned sorted_slot(input logic [TEAM_W-1:0] t);
    int unsigned i;
    if (row_count == 0 || row_team[0] > t) return 0;
    for (i = 1; i < row_count; i++) begin
      if (row_team[i] > t) return i;
    end
    return row_count;
  endfunction

  // predictor: apply one command to the row and give the result
  function automatic result_t queue_step(input cmd_item_t it);
    result_t     r;
    int unsigned pos;
    int unsigned i;
    r.member = '0;
    r.team   = '0;
    if (it.cmd == CMD_DEQUEUE || it.cmd == CMD_SPARE) begin
      if (row_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.member = row_member[0];
        r.team   = row_team[0];
        for (i = 1; i < row_count; i++) begin
          row_member[i-1] = row_member[i];
          row_team[i-1]   = row_team[i];
        end
        row_count--;
        r.status = ST_DEQUEUED;
      end
    end else if (row_count >= DEPTH) begin
      r.status = ST_FULL;
    end else begin
      pos = (it.cmd == CMD_SORTED) ? sorted_slot(it.team) : row_count;
      for (i = row_count; i > pos; i--) begin
        row_member[i] = row_member[i-1];
        row_team[i]   = row_team[i-1];
      end
      row_member[pos] = it.member;
      row_team[pos]   = it.team;
      row_count++;
      r.status = ST_INSERTED;
    end
    r.occ = OCC_W'(row_count);
    return r;
  endfunction

  function automatic cmd_item_t make_item(input logic [1:0] c, input logic [MEM_W-1:0] m,
                                          input logic [TEAM_W-1:0] t);
    cmd_item_t it;
    it.cmd    = c;
    it.member = m;
    it.team   = t;
    return it;
  endfunction

  function automatic logic [TEAM_W-1:0] pick_team(input team_mode_e tm);
    int r;
    r = $urandom_range(0, 3);
    case (tm)
      TM_NARROW: return TEAM_W'($urandom_range(0, 3));
      TM_EDGES: begin
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r == 2) return TEAM_W'($urandom_range(0, 2));
        return TEAM_W'($urandom_range(253, 255));
      end
      default: return TEAM_W'($urandom);
    endcase
  endfunction

  function automatic logic [MEM_W-1:0] pick_member();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return MEM_W'($urandom);
  endfunction

  // driver: hold an offered item until taken, then a gap or the next item
  always @(negedge clk) begin : drive_cmd
    cmd_item_t nxt;
    if (rst_n) begin
      if (cmd_if.valid && !cmd_taken) begin
        // keep offering the same item
      end else if (send_gap > 0) begin
        cmd_if.valid <= 1'b0;
        send_gap--;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        cmd_if.cmd    <= nxt.cmd;
        cmd_if.member <= nxt.member;
        cmd_if.team   <= nxt.team;
        cmd_if.valid  <= 1'b1;
        if ($urandom_range(0, 63) == 0) calm_send = ~calm_send;
        send_gap = pick_gap(calm_send);
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // receiver readiness, with random stalls and the long hold-off
  always @(negedge clk) begin : drive_ready
    if (rst_n) begin
      if (res_taken) begin
        if ($urandom_range(0, 63) == 0) calm_recv = ~calm_recv;
        recv_gap = pick_gap(calm_recv);
      end
      if (hold_recv) begin
        res_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        res_if.ready <= 1'b0;
        recv_gap--;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // monitor: check the result taken at this edge, then predict the item taken
  always @(posedge clk) begin : monitor
    result_t exp_r;
    cmd_item_t it;
    if (rst_n) begin
      cmd_taken <= cmd_if.valid && cmd_if.ready;
      res_taken <= res_if.valid && res_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result item: status %0d member %h team %h occupancy %0d",
                   $time, res_if.status, res_if.out_member, res_if.out_team,
                   res_if.occupancy);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (res_if.status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                     res_if.status);
            errors++;
          end
          if (res_if.out_member !== exp_r.member) begin
            $display("%0t: out_member expected %h actual %h", $time, exp_r.member,
                     res_if.out_member);
            errors++;
          end
          if (res_if.out_team !== exp_r.team) begin
            $display("%0t: out_team expected %h actual %h", $time, exp_r.team,
                     res_if.out_team);
            errors++;
          end
          if (res_if.occupancy !== exp_r.occ) begin
            $display("%0t: occupancy expected %0d actual %0d", $time, exp_r.occ,
                     res_if.occupancy);
            errors++;
          end
        end
      end
      if (cmd_if.valid && cmd_if.ready) begin
        it = make_item(cmd_if.cmd, cmd_if.member, cmd_if.team);
        expected_results.push_back(queue_step(it));
        accepted_items <= accepted_items + 1;
      end
    end
  end

  // long receiver hold-offs while the sender keeps offering
  initial begin : recv_hold_off
    wait (accepted_items >= 120);
    hold_recv = 1'b1;
    repeat (80) @(posedge clk);
    hold_recv = 1'b0;
    wait (accepted_items >= 900);
    hold_recv = 1'b1;
    repeat (150) @(posedge clk);
    hold_recv = 1'b0;
  end

  // run limit
  initial begin : run_limit
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main
    phase_e     ph;
    team_mode_e tm;
    int         r;
    int         n;
    logic [1:0] c;

    cmd_if.valid  = 1'b0;
    cmd_if.cmd    = CMD_SORTED;
    cmd_if.member = '0;
    cmd_if.team   = '0;
    res_if.ready  = 1'b0;
    rst_n         = 1'b0;
    row_count     = 0;
    ph            = PH_MIXED;
    tm            = TM_ANY;

    // directed: empty dequeues, head and tail inserts, ties, out-of-order row
    pending_items.push_back(make_item(CMD_DEQUEUE, 16'hffff, 8'hff));
    pending_items.push_back(make_item(CMD_SPARE, 16'h0000, 8'h00));
    pending_items.push_back(make_item(CMD_SORTED, 16'hffff, 8'd100));
    pending_items.push_back(make_item(CMD_SORTED, 16'h0001, 8'd50));
    pending_items.push_back(make_item(CMD_SORTED, 16'h0002, 8'd255));
    pending_items.push_back(make_item(CMD_SORTED, 16'h0003, 8'd100));
    pending_items.push_back(make_item(CMD_APPEND, 16'h0004, 8'd0));
    pending_items.push_back(make_item(CMD_SORTED, 16'h0005, 8'd200));
    pending_items.push_back(make_item(CMD_SORTED, 16'h0000, 8'd0));
    // fill to the top with appends, then inserts into a full row
    for (int i = 0; i < 9; i++)
      pending_items.push_back(make_item(CMD_APPEND, MEM_W'(16'h0100 + i), TEAM_W'(i * 29)));
    pending_items.push_back(make_item(CMD_SORTED, 16'haaaa, 8'd7));
    pending_items.push_back(make_item(CMD_APPEND, 16'h5555, 8'd7));
    pending_items.push_back(make_item(CMD_DEQUEUE, 16'h1234, 8'h5a));
    pending_items.push_back(make_item(CMD_SPARE, 16'hffff, 8'hff));

    // random: phases that fill, drain or mix, with ties and extremes of team
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) begin
        r  = $urandom_range(0, 2);
        ph = phase_e'(r);
        r  = $urandom_range(0, 2);
        tm = team_mode_e'(r);
      end
      n = $urandom_range(0, 99);
      if ((ph == PH_FILL && n < 80) || (ph == PH_DRAIN && n < 30) ||
          (ph == PH_MIXED && n < 55)) begin
        c = ($urandom_range(0, 9) < 7) ? CMD_SORTED : CMD_APPEND;
      end else begin
        c = ($urandom_range(0, 6) == 0) ? CMD_SPARE : CMD_DEQUEUE;
      end
      pending_items.push_back(make_item(c, pick_member(), pick_team(tm)));
    end
    total_items = pending_items.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    wait (accepted_items == total_items);
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk);

    if (errors == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
